>>> hw/rtl/fpn_pkg.sv
package fpn_pkg;

  localparam int unsigned TableSize  = 256;
  localparam int unsigned TblBits    = $clog2(TableSize);
  localparam int unsigned MaxOctaves = 20;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned MulW       = 26;
  localparam int unsigned ProdW      = 2 * MulW;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  localparam logic [1:0] CfgOctaves     = 2'd0;
  localparam logic [1:0] CfgPersistence = 2'd1;
  localparam logic [1:0] CfgScale       = 2'd2;

  typedef struct packed {
    logic               is_query;
    logic [7:0]         table_index;
    logic [7:0]         table_value;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
  } item_t;

  typedef struct packed {
    logic [4:0]  octave_count;
    logic [16:0] persistence;
    logic [22:0] output_scale;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_OCTAVE,
    ST_SCALE,
    ST_OUT
  } back_state_e;

  // Gradient u +- 2v, with u and v swapped when bit 2 of the hash is set.
  function automatic logic signed [20:0] grad(input logic [2:0] h,
                                              input logic signed [17:0] dx,
                                              input logic signed [17:0] dy);
    logic signed [20:0] u;
    logic signed [20:0] v;
    logic signed [20:0] a;
    logic signed [20:0] b;
    u = h[2] ? 21'(dy) : 21'(dx);
    v = h[2] ? 21'(dx) : 21'(dy);
    a = h[0] ? -u : u;
    b = h[1] ? -(v <<< 1) : (v <<< 1);
    return a + b;
  endfunction

endpackage

>>> hw/rtl/fractal_perlin_noise_2d.sv
// Fractal 2D Perlin noise unit.
// Input words arrive on a valid/ready channel. A word with kind 0 loads one
// entry of the 256-entry permutation table and gives no result; a word with
// kind 1 is a noise query on signed Q15.16 coordinates and gives one result
// word on the output valid/ready channel.
// Incoming words pass through a two-word queue, so the input keeps accepting
// while a query is being worked on. A load is written into the table as the
// sequencer takes it, and the sequencer stays idle. A query runs through the
// octave state once per octave, then the scale and output states, until its
// result is registered; one shared multiplier and one table read port carry
// the sixteen steps of each octave. Then the sequencer takes the next word.
// The three configuration registers are written through the write port with
// no wait and may only be changed while the unit is idle.
// Reset empties the queue and the output register and loads the register
// defaults; the table content is undefined until written.
// When the receiver stalls, the finished result is held and the sequencer
// waits before writing the next one; the queue fills and then input stalls.
module fractal_perlin_noise_2d (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic [7:0]         table_index_i,
  input  logic [7:0]         table_value_i,
  input  logic signed [31:0] x_coord_i,
  input  logic signed [31:0] y_coord_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] noise_value_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [22:0]        cfg_data_i
);

  fpn_pkg::cfg_t  cfg_q;
  fpn_pkg::item_t item;
  logic           item_valid, item_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.octave_count <= 5'd1;
      cfg_q.persistence  <= 17'd32768;
      cfg_q.output_scale <= 23'd65536;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        fpn_pkg::CfgOctaves:     cfg_q.octave_count <= cfg_data_i[4:0];
        fpn_pkg::CfgPersistence: cfg_q.persistence  <= cfg_data_i[16:0];
        fpn_pkg::CfgScale:       cfg_q.output_scale <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  fpn_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .table_index_i (table_index_i),
    .table_value_i (table_value_i),
    .x_coord_i     (x_coord_i),
    .y_coord_i     (y_coord_i),
    .item_valid_o  (item_valid),
    .item_ready_i  (item_ready),
    .item_o        (item)
  );

  fpn_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .item_valid_i  (item_valid),
    .item_ready_o  (item_ready),
    .item_i        (item),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .noise_value_o (noise_value_o)
  );

endmodule

>>> hw/rtl/fpn_front.sv
module fpn_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                kind_i,
  input  logic [7:0]          table_index_i,
  input  logic [7:0]          table_value_i,
  input  logic signed [31:0]  x_coord_i,
  input  logic signed [31:0]  y_coord_i,
  output logic                item_valid_o,
  input  logic                item_ready_i,
  output fpn_pkg::item_t      item_o
);

  localparam int unsigned PW = fpn_pkg::QueuePtrW;
  localparam int unsigned CW = fpn_pkg::QueuePtrW + 1;

  fpn_pkg::item_t mem_q [fpn_pkg::QueueDepth];
  logic [PW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  count_q, count_d;
  logic           push, pop;
  fpn_pkg::item_t item_in;

  assign in_ready_o   = (count_q != CW'(fpn_pkg::QueueDepth));
  assign item_valid_o = (count_q != '0);
  assign item_o       = mem_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_valid_o && item_ready_i;

  always_comb begin
    item_in.is_query    = kind_i;
    item_in.table_index = table_index_i;
    item_in.table_value = table_value_i;
    item_in.x_coord     = x_coord_i;
    item_in.y_coord     = y_coord_i;
    wr_ptr_d = push ? PW'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = pop ? PW'(rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d  = count_q + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

>>> hw/rtl/fpn_back.sv
module fpn_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fpn_pkg::cfg_t      cfg_i,
  input  logic               item_valid_i,
  output logic               item_ready_o,
  input  fpn_pkg::item_t     item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] noise_value_o
);

  localparam int unsigned W  = fpn_pkg::MulW;
  localparam int unsigned PW = fpn_pkg::ProdW;
  localparam int unsigned F  = fpn_pkg::FracBits;
  localparam int unsigned TB = fpn_pkg::TblBits;
  localparam int unsigned CB = F + TB;
  localparam logic signed [W-1:0] OneFx     = W'(1 << F);
  localparam logic signed [W-1:0] FifteenFx = W'(15 << F);
  localparam logic signed [W-1:0] TenFx     = W'(10 << F);
  localparam logic [16:0]         PersOne   = 17'd65536;
  localparam logic [4:0]          OctMax    = 5'(fpn_pkg::MaxOctaves);

  fpn_pkg::back_state_e state_q, state_d;
  logic [3:0]  step_q, step_d;
  logic [4:0]  oct_left_q;
  logic [CB-1:0] xs_q, ys_q;
  logic [16:0] pers_q;
  logic [22:0] scale_q;
  logic [4:0]  oct_clamped;
  logic [16:0] pers_clamped;

  logic [7:0]  perm_mem [fpn_pkg::TableSize];
  logic [7:0]  rd_q;
  logic [TB-1:0] raddr;
  logic        mem_we;

  logic [7:0] px0_q, px1_q, h1_q, h2_q, h3_q, h4_q;
  logic signed [W-1:0]  b_q, u_q, v_q, r1_q, r2_q, n_q, total_q, amp_q;
  logic signed [PW-1:0] p_q;
  logic signed [PW-F-1:0] pv_full;
  logic signed [W-1:0]  pv, op_a, op_b, fx, fy, ea_x, ea_y;
  logic signed [17:0]   dx0, dx1, dy0, dy1;
  logic signed [W-1:0]  g1, g2, g3, g4;
  logic [TB-1:0] cx, cy;
  logic          start;
  logic          mul_en;
  logic          out_write;
  logic          out_valid_q;
  logic signed [31:0] out_q;
  logic signed [31:0] sat;

  assign pv_full = p_q[PW-1:F];
  assign pv      = pv_full[W-1:0];
  assign fx   = W'({1'b0, xs_q[F-1:0]});
  assign fy   = W'({1'b0, ys_q[F-1:0]});
  assign ea_x = (fx <<< 2) + (fx <<< 1) - FifteenFx;
  assign ea_y = (fy <<< 2) + (fy <<< 1) - FifteenFx;
  assign cx   = xs_q[CB-1:F];
  assign cy   = ys_q[CB-1:F];
  assign dx0  = 18'(fx);
  assign dy0  = 18'(fy);
  assign dx1  = 18'(fx - OneFx);
  assign dy1  = 18'(fy - OneFx);
  assign g1   = W'(fpn_pkg::grad(h1_q[2:0], dx0, dy0));
  assign g2   = W'(fpn_pkg::grad(h2_q[2:0], dx1, dy0));
  assign g3   = W'(fpn_pkg::grad(h3_q[2:0], dx0, dy1));
  assign g4   = W'(fpn_pkg::grad(h4_q[2:0], dx1, dy1));

  assign oct_clamped  = (cfg_i.octave_count > OctMax) ? OctMax : cfg_i.octave_count;
  assign pers_clamped = (cfg_i.persistence > PersOne) ? PersOne : cfg_i.persistence;

  assign item_ready_o  = (state_q == fpn_pkg::ST_IDLE);
  assign start         = item_valid_i && item_ready_o && item_i.is_query;
  assign mem_we        = item_valid_i && item_ready_o && !item_i.is_query;
  assign out_valid_o   = out_valid_q;
  assign noise_value_o = out_q;

  always_comb begin
    if (pv_full > (PW-F)'(32'sh7fffffff)) begin
      sat = 32'sh7fffffff;
    end else if (pv_full < -(PW-F)'(33'sh080000000)) begin
      sat = 32'sh80000000;
    end else begin
      sat = pv_full[31:0];
    end
  end

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    op_a      = fx;
    op_b      = fx;
    mul_en    = 1'b0;
    out_write = 1'b0;
    raddr     = cx;
    case (state_q)
      fpn_pkg::ST_IDLE: begin
        step_d = 4'd0;
        if (start) begin
          state_d = (oct_clamped == 5'd0) ? fpn_pkg::ST_SCALE : fpn_pkg::ST_OCTAVE;
        end
      end
      fpn_pkg::ST_OCTAVE: begin
        step_d = step_q + 4'd1;
        mul_en = 1'b1;
        case (step_q)
          4'd0: begin
            op_b  = ea_x;
          end
          4'd1: begin
            raddr = cx + TB'(1);
          end
          4'd2: begin
            op_a  = pv;
            raddr = TB'(px0_q) + cy;
          end
          4'd3: begin
            op_a  = pv;
            op_b  = b_q;
            raddr = TB'(px1_q) + cy;
          end
          4'd4: begin
            op_a  = fy;
            op_b  = ea_y;
            raddr = TB'(px0_q) + cy + TB'(1);
          end
          4'd5: begin
            op_a  = fy;
            op_b  = fy;
            raddr = TB'(px1_q) + cy + TB'(1);
          end
          4'd6: begin
            op_a = pv;
            op_b = fy;
          end
          4'd7: begin
            op_a = pv;
            op_b = b_q;
          end
          4'd8: begin
            op_a = u_q;
            op_b = g2 - g1;
          end
          4'd9: begin
            op_a = u_q;
            op_b = g4 - g3;
          end
          4'd11: begin
            op_a = v_q;
            op_b = r2_q - r1_q;
          end
          4'd13: begin
            op_a = n_q;
            op_b = amp_q;
          end
          4'd14: begin
            op_a = amp_q;
            op_b = W'(pers_q);
          end
          4'd15: begin
            mul_en = 1'b0;
            if (oct_left_q == 5'd1) begin
              state_d = fpn_pkg::ST_SCALE;
            end
          end
          default: begin
            mul_en = 1'b0;
          end
        endcase
      end
      fpn_pkg::ST_SCALE: begin
        mul_en  = 1'b1;
        op_a    = total_q;
        op_b    = W'(scale_q);
        state_d = fpn_pkg::ST_OUT;
      end
      fpn_pkg::ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_write = 1'b1;
          state_d   = fpn_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fpn_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fpn_pkg::ST_IDLE;
      step_q  <= 4'd0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      perm_mem[item_i.table_index[TB-1:0]] <= item_i.table_value;
    end
    rd_q <= perm_mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q        <= '0;
      xs_q       <= '0;
      ys_q       <= '0;
      oct_left_q <= 5'd0;
      pers_q     <= '0;
      scale_q    <= '0;
      total_q    <= '0;
      amp_q      <= '0;
      b_q        <= '0;
      u_q        <= '0;
      v_q        <= '0;
      r1_q       <= '0;
      r2_q       <= '0;
      n_q        <= '0;
      px0_q      <= '0;
      px1_q      <= '0;
      h1_q       <= '0;
      h2_q       <= '0;
      h3_q       <= '0;
      h4_q       <= '0;
    end else begin
      if (mul_en) begin
        p_q <= PW'(op_a) * PW'(op_b);
      end
      if (start) begin
        xs_q       <= item_i.x_coord[CB-1:0];
        ys_q       <= item_i.y_coord[CB-1:0];
        oct_left_q <= oct_clamped;
        pers_q     <= pers_clamped;
        scale_q    <= cfg_i.output_scale;
        total_q    <= '0;
        amp_q      <= OneFx;
      end
      if (state_q == fpn_pkg::ST_OCTAVE) begin
        case (step_q)
          4'd1: begin
            b_q   <= pv + TenFx;
            px0_q <= rd_q;
          end
          4'd2: px1_q <= rd_q;
          4'd3: h1_q <= rd_q;
          4'd4: begin
            u_q  <= pv;
            h2_q <= rd_q;
          end
          4'd5: begin
            b_q  <= pv + TenFx;
            h3_q <= rd_q;
          end
          4'd6: h4_q <= rd_q;
          4'd8: v_q <= pv;
          4'd9: r1_q <= g1 + pv;
          4'd10: r2_q <= g3 + pv;
          4'd12: n_q <= r1_q + pv;
          4'd14: total_q <= total_q + pv;
          4'd15: begin
            amp_q      <= pv;
            xs_q       <= {xs_q[CB-2:0], 1'b0};
            ys_q       <= {ys_q[CB-2:0], 1'b0};
            oct_left_q <= oct_left_q - 5'd1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (out_write) begin
      out_valid_q <= 1'b1;
      out_q       <= sat;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

endmodule

>>> dv/tb_fractal_perlin_noise_2d.sv
module tb_fractal_perlin_noise_2d;

  localparam logic      KindLoad   = 1'b0;
  localparam logic      KindQuery  = 1'b1;
  localparam logic [1:0] CfgUnused = 2'd3;
  localparam longint    OneQ16     = 64'sd65536;
  localparam int        DrainWait  = 320;
  localparam int        StallLimit = 50000;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               kind_i;
  logic [7:0]         table_index_i;
  logic [7:0]         table_value_i;
  logic signed [31:0] x_coord_i;
  logic signed [31:0] y_coord_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [31:0] noise_value_o;
  logic               cfg_we_i;
  logic [1:0]         cfg_index_i;
  logic [22:0]        cfg_data_i;

  fractal_perlin_noise_2d uut (.*);

  logic [7:0]  perm_shadow [fpn_pkg::TableSize];
  logic [4:0]  octaves_shadow;
  logic [16:0] persist_shadow;
  logic [22:0] scale_shadow;

  logic signed [31:0] expected_noise [$];
  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  int n_loads;
  int n_queries;
  int n_results;
  int quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint fade_q16(input longint t);
    longint a;
    longint b;
    longint t2;
    longint t3;
    a  = 6 * t - 15 * OneQ16;
    b  = ((t * a) >>> 16) + 10 * OneQ16;
    t2 = (t * t) >>> 16;
    t3 = (t2 * t) >>> 16;
    return (t3 * b) >>> 16;
  endfunction

  function automatic longint lerp_q16(input longint w, input longint lo, input longint hi);
    return lo + ((w * (hi - lo)) >>> 16);
  endfunction

  function automatic longint corner_grad(input logic [7:0] h, input longint dx,
                                         input longint dy);
    longint u;
    longint v;
    u = h[2] ? dy : dx;
    v = h[2] ? dx : dy;
    return (h[0] ? -u : u) + (h[1] ? -2 * v : 2 * v);
  endfunction

  function automatic longint cell_noise(input longint xs, input longint ys);
    logic [7:0] cx;
    logic [7:0] cy;
    logic [7:0] px0;
    logic [7:0] px1;
    longint fx;
    longint fy;
    longint u;
    longint v;
    longint r1;
    longint r2;
    cx  = 8'((xs >>> 16) & 255);
    cy  = 8'((ys >>> 16) & 255);
    fx  = xs & 64'hFFFF;
    fy  = ys & 64'hFFFF;
    px0 = perm_shadow[cx];
    px1 = perm_shadow[8'(cx + 8'd1)];
    u   = fade_q16(fx);
    v   = fade_q16(fy);
    r1  = lerp_q16(u, corner_grad(perm_shadow[8'(px0 + cy)], fx, fy),
                   corner_grad(perm_shadow[8'(px1 + cy)], fx - OneQ16, fy));
    r2  = lerp_q16(u, corner_grad(perm_shadow[8'(px0 + cy + 8'd1)], fx, fy - OneQ16),
                   corner_grad(perm_shadow[8'(px1 + cy + 8'd1)], fx - OneQ16,
                               fy - OneQ16));
    return lerp_q16(v, r1, r2);
  endfunction

  function automatic logic signed [31:0] fractal_noise(input logic signed [31:0] x,
                                                       input logic signed [31:0] y);
    longint xw;
    longint yw;
    longint total;
    longint amp;
    longint pers;
    longint res;
    int     oct;
    xw    = longint'(x);
    yw    = longint'(y);
    total = 0;
    amp   = OneQ16;
    oct   = (octaves_shadow > fpn_pkg::MaxOctaves) ? fpn_pkg::MaxOctaves : octaves_shadow;
    pers  = (persist_shadow > 17'd65536) ? 65536 : longint'(persist_shadow);
    for (int i = 0; i < oct; i++) begin
      total += (cell_noise(xw << i, yw << i) * amp) >>> 16;
      amp = (amp * pers) >> 16;
    end
    res = (total * longint'(scale_shadow)) >>> 16;
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    if (res < -64'sd2147483648) res = -64'sd2147483648;
    return 32'(res);
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  // Receiver side: random stalls, and each accepted word is checked.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      if (out_valid_o && out_ready_i) begin
        n_results++;
        if (expected_noise.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0d", noise_value_o));
        end else begin
          if (noise_value_o !== expected_noise[0])
            report_mismatch($sformatf("noise_value %0d, expected %0d",
                                      noise_value_o, expected_noise[0]));
          void'(expected_noise.pop_front());
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("timeout: no word accepted for %0d cycles", StallLimit);
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic send_word(input logic kind, input logic [7:0] idx, input logic [7:0] val,
                           input logic signed [31:0] x, input logic signed [31:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= kind;
    table_index_i <= idx;
    table_value_i <= val;
    x_coord_i     <= x;
    y_coord_i     <= y;
    do @(posedge clk_i); while (!in_ready_o);
    if (kind == KindLoad) begin
      perm_shadow[idx] = val;
      n_loads++;
    end else begin
      expected_noise = {expected_noise, fractal_noise(x, y)};
      n_queries++;
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_noise.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [4:0] oct, input logic [16:0] pers,
                            input logic [22:0] scale);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= fpn_pkg::CfgOctaves;
    cfg_data_i  <= 23'(oct);
    @(posedge clk_i);
    cfg_index_i <= fpn_pkg::CfgPersistence;
    cfg_data_i  <= 23'(pers);
    @(posedge clk_i);
    cfg_index_i <= fpn_pkg::CfgScale;
    cfg_data_i  <= scale;
    @(posedge clk_i);
    cfg_index_i <= CfgUnused;
    cfg_data_i  <= 23'($urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    octaves_shadow = oct;
    persist_shadow = pers;
    scale_shadow   = scale;
  endtask

  task automatic query(input logic signed [31:0] x, input logic signed [31:0] y);
    send_word(KindQuery, 8'($urandom), 8'($urandom), x, y);
  endtask

  task automatic test_table_fill();
    for (int i = 0; i < fpn_pkg::TableSize; i++)
      send_word(KindLoad, 8'(i), (i == 0) ? 8'hFF : (i == 255) ? 8'h00 : 8'($urandom),
                $urandom, $urandom);
  endtask

  task automatic test_coordinate_extremes();
    query(32'sh0, 32'sh0);
    query(32'sh7FFFFFFF, 32'sh7FFFFFFF);
    query(32'sh80000000, 32'sh80000000);
    query(32'sh0000FFFF, 32'sh00FFFFFF);
    query(32'sh00FF8000, 32'shFFFF0001);
    query(32'shFFFFFFFF, 32'sh00010000);
    query(32'sh12345678, 32'shEDCBA987);
  endtask

  task automatic test_register_extremes();
    write_regs(5'd0, 17'd32768, 23'd65536);
    query($urandom, $urandom);
    write_regs(5'd20, 17'd65536, 23'd6553600);
    query(32'sh00128000, 32'sh0007C000);
    query($urandom, $urandom);
    write_regs(5'd31, 17'h1FFFF, 23'h7FFFFF);
    query(32'sh00008000, 32'sh00004000);
    query($urandom, $urandom);
    write_regs(5'd21, 17'd65537, 23'd0);
    query($urandom, $urandom);
    write_regs(5'd3, 17'd0, 23'd6553600);
    query($urandom, $urandom);
  endtask

  task automatic test_random_traffic(input int count, input int snd, input int rcv);
    logic signed [31:0] x;
    logic signed [31:0] y;
    send_idle_pct = snd;
    recv_idle_pct = rcv;
    for (int i = 0; i < count; i++) begin
      if (i % 80 == 0) begin
        if ($urandom_range(9) == 0)
          write_regs(5'($urandom_range(20, 31)), 17'($urandom_range(65536, 131071)),
                     23'($urandom));
        else
          write_regs(5'($urandom_range(0, 5)), 17'($urandom_range(0, 65536)),
                     23'($urandom_range(0, 6553600)));
      end
      if (i == count / 2) wait_drained();
      if ($urandom_range(99) < 12) begin
        send_word(KindLoad, 8'($urandom), 8'($urandom), $urandom, $urandom);
      end else begin
        x = $urandom;
        y = $urandom;
        if ($urandom_range(1)) begin
          x = 32'(signed'(x) >>> $urandom_range(8, 30));
          y = 32'(signed'(y) >>> $urandom_range(8, 30));
        end
        query(x, y);
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    kind_i        = KindLoad;
    table_index_i = '0;
    table_value_i = '0;
    x_coord_i     = '0;
    y_coord_i     = '0;
    out_ready_i   = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = fpn_pkg::CfgOctaves;
    cfg_data_i    = '0;
    send_idle_pct = 9;
    recv_idle_pct = 58;
    mismatches    = 0;
    n_loads       = 0;
    n_queries     = 0;
    n_results     = 0;
    quiet_cycles  = 0;
    octaves_shadow = 5'd1;
    persist_shadow = 17'd32768;
    scale_shadow   = 23'd65536;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_table_fill();
    test_coordinate_extremes();
    test_register_extremes();
    test_random_traffic(245, 9, 58);
    test_random_traffic(245, 58, 9);
    test_random_traffic(240, 0, 0);
    wait_drained();

    $display("Covered %0d table loads and %0d noise queries, %0d results checked,",
             n_loads, n_queries, n_results);
    $display("over octave counts 0 to 31, persistence and scale at both extremes.");
    if (mismatches == 0 && expected_noise.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> fractal_perlin_noise_2d.f
hw/rtl/fpn_pkg.sv
hw/rtl/fpn_front.sv
hw/rtl/fpn_back.sv
hw/rtl/fractal_perlin_noise_2d.sv
dv/tb_fractal_perlin_noise_2d.sv
